// ===== sv/v3a_pkg.sv =====
// Shared types, constants and codes for the three-component vector ALU.
`default_nettype none

package v3a_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned NUM_W     = PROD_W + DATA_W;

  // Largest positive result: the signed word range, capped at the field range
  localparam logic [63:0] SAT_HI_L = (WORD_BITS >= DATA_W) ? 64'h7FFF_FFFF :
                                     ((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_HI_A = ACC_W'(SAT_HI_L);
  localparam logic signed [ACC_W-1:0] SAT_LO_A = -SAT_HI_A - ACC_W'(1);
  localparam logic [NUM_W-1:0]        SAT_HI_N = NUM_W'(SAT_HI_L);
  localparam logic [NUM_W-1:0]        SAT_LO_N = SAT_HI_N + NUM_W'(1);

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_ADDS  = 4'd2,
    CMD_SUBS  = 4'd3,
    CMD_SCALE = 4'd4,
    CMD_DOT   = 4'd5,
    CMD_CROSS = 4'd6,
    CMD_MAG   = 4'd7,
    CMD_PROJ  = 4'd8,
    CMD_NORM  = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZDIV = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                     op;
    logic                     iter;
    logic                     a_zero;
    logic                     b_zero;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
    logic signed [DATA_W-1:0] bx;
    logic signed [DATA_W-1:0] by;
    logic signed [DATA_W-1:0] bz;
    logic signed [DATA_W-1:0] sc;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    logic signed [DATA_W-1:0] rz;
    logic signed [DATA_W-1:0] sc;
    status_e                  status;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/v3a_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
`default_nettype none

module v3a_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= ptr_next(wr_q);
      end
      if (do_pop) begin
        rd_q <= ptr_next(rd_q);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/v3a_front.sv =====
// Front end: takes input transfers, decodes and classifies them for the back end.
`default_nettype none

module v3a_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [3:0]                    cmd_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] ax_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] ay_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] az_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] bx_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] by_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] bz_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] sc_i,
  output logic                               full_o,
  output logic                               q_push_o,
  output v3a_pkg::item_t                     q_item_o,
  input  wire logic                          q_full_i
);

  import v3a_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept, fwd;

  assign fwd      = valid_q && !q_full_i;
  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = fwd;
  assign q_item_o = item_q;
  assign valid_d  = accept || (valid_q && !fwd);

  always_comb begin
    item_d.op     = cmd_e'(cmd_i);
    item_d.iter   = (cmd_i == CMD_MAG) || (cmd_i == CMD_PROJ) || (cmd_i == CMD_NORM);
    item_d.a_zero = ((ax_i | ay_i | az_i) == '0);
    item_d.b_zero = ((bx_i | by_i | bz_i) == '0);
    item_d.ax     = ax_i;
    item_d.ay     = ay_i;
    item_d.az     = az_i;
    item_d.bx     = bx_i;
    item_d.by     = by_i;
    item_d.bz     = bz_i;
    item_d.sc     = sc_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/v3a_back.sv =====
// Back end: product and sum pipeline plus a shared square-root and divide unit.
`default_nettype none

module v3a_back (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire v3a_pkg::item_t item_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output v3a_pkg::res_t res_o,
  output logic        push_o,
  input  wire logic   full_i
);

  import v3a_pkg::*;

  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned SQRT_STEPS = DATA_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);
  localparam int unsigned SQ_CW      = $clog2(SQRT_STEPS);
  localparam int unsigned SH_W       = $clog2(PROD_W);

  typedef enum logic [4:0] {
    EX_IDLE = 5'b00001,
    EX_SQRT = 5'b00010,
    EX_MUL  = 5'b00100,
    EX_DIV  = 5'b01000,
    EX_DONE = 5'b10000
  } ex_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ovf;
  } sat_t;

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
    sat_t r;
    r.val = v[DATA_W-1:0];
    r.ovf = 1'b0;
    if (v > SAT_HI_A) begin
      r.val = SAT_HI_A[DATA_W-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_LO_A) begin
      r.val = SAT_LO_A[DATA_W-1:0];
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  // Signed saturation of a magnitude with a separate sign
  function automatic sat_t sat_mag(input logic [NUM_W-1:0] q, input logic neg);
    sat_t r;
    r.ovf = 1'b0;
    r.val = neg ? DATA_W'(0) - q[DATA_W-1:0] : q[DATA_W-1:0];
    if (!neg && (q > SAT_HI_N)) begin
      r.val = SAT_HI_A[DATA_W-1:0];
      r.ovf = 1'b1;
    end else if (neg && (q > SAT_LO_N)) begin
      r.val = SAT_LO_A[DATA_W-1:0];
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~$unsigned(v) + DATA_W'(1)) : $unsigned(v);
  endfunction

  // ---------------- stage 1: operand select, products, plain sums
  logic signed [DATA_W-1:0] ia [3];
  logic signed [DATA_W-1:0] ib [3];
  logic signed [DATA_W-1:0] ma [6];
  logic signed [DATA_W-1:0] mb [6];
  logic signed [DATA_W:0]   addv_d [3];
  logic signed [DATA_W:0]   addv_q [3];
  logic signed [PROD_W-1:0] p_q [6];
  logic                     s1_valid_q;
  item_t                    s1_item_q;
  logic                     s1_en;

  assign ia[0] = item_i.ax;
  assign ia[1] = item_i.ay;
  assign ia[2] = item_i.az;
  assign ib[0] = item_i.bx;
  assign ib[1] = item_i.by;
  assign ib[2] = item_i.bz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]     = ia[i];
      mb[i]     = ib[i];
      ma[i + 3] = ib[i];
      mb[i + 3] = ib[i];
      addv_d[i] = '0;
      case (item_i.op)
        CMD_ADD:   addv_d[i] = (DATA_W + 1)'(ia[i]) + (DATA_W + 1)'(ib[i]);
        CMD_SUB:   addv_d[i] = (DATA_W + 1)'(ia[i]) - (DATA_W + 1)'(ib[i]);
        CMD_ADDS:  addv_d[i] = (DATA_W + 1)'(ia[i]) + (DATA_W + 1)'(item_i.sc);
        CMD_SUBS:  addv_d[i] = (DATA_W + 1)'(ia[i]) - (DATA_W + 1)'(item_i.sc);
        CMD_SCALE: mb[i] = item_i.sc;
        CMD_CROSS: begin
          ma[i]     = ia[(i + 1) % 3];
          mb[i]     = ib[(i + 2) % 3];
          ma[i + 3] = ia[(i + 2) % 3];
          mb[i + 3] = ib[(i + 1) % 3];
        end
        CMD_MAG, CMD_NORM: mb[i] = ia[i];
        default: ;
      endcase
    end
  end

  // ---------------- stage 2: combine products
  logic                     s2_valid_q;
  item_t                    s2_item_q;
  logic signed [ACC_W-1:0]  v_d [3];
  logic signed [ACC_W-1:0]  v_q [3];
  logic signed [ACC_W-1:0]  dsum_q, nsum_q;
  logic                     s2_en, s2_go;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (s1_item_q.op)
        CMD_ADD, CMD_SUB, CMD_ADDS, CMD_SUBS: v_d[i] = ACC_W'(addv_q[i]);
        CMD_SCALE: v_d[i] = ACC_W'(p_q[i]);
        CMD_CROSS: v_d[i] = ACC_W'(p_q[i]) - ACC_W'(p_q[i + 3]);
        default:   v_d[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_item_q <= item_i;
      for (int i = 0; i < 6; i++) begin
        p_q[i] <= ma[i] * mb[i];
      end
      for (int i = 0; i < 3; i++) begin
        addv_q[i] <= addv_d[i];
      end
    end
    if (s2_en) begin
      s2_item_q <= s1_item_q;
      for (int i = 0; i < 3; i++) begin
        v_q[i] <= v_d[i];
      end
      dsum_q <= ACC_W'(p_q[0]) + ACC_W'(p_q[1]) + ACC_W'(p_q[2]);
      nsum_q <= ACC_W'(p_q[3]) + ACC_W'(p_q[4]) + ACC_W'(p_q[5]);
    end
  end

  // ---------------- execution unit for magnitude, projection, normalize
  ex_e                      ex_q, ex_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     zdiv_q, zdiv_d;
  cmd_e                     ex_op_q;
  logic [PROD_W-1:0]        sqs_q, sqr_q, sqs_d, sqr_d, sq_bit, sq_try;
  logic [SH_W-1:0]          sq_sh;
  logic [PROD_W-1:0]        dv_q, dm_q;
  logic [DATA_W-1:0]        mag_q [3];
  logic                     neg_q [3];
  logic [NUM_W-1:0]         num_q [3];
  logic [NUM_W-1:0]         num_d [3];
  logic [PROD_W-1:0]        rem_q [3];
  logic [PROD_W-1:0]        rem_d [3];
  logic [PROD_W:0]          rsh [3];
  logic [PROD_W:0]          rdiff [3];
  logic [PROD_W-1:0]        prod_u [3];
  logic signed [DATA_W-1:0] s2a [3];
  logic signed [DATA_W-1:0] s2b [3];
  logic signed [ACC_W-1:0]  dabs;
  logic                     dneg, sq_last, div_last, ex_load;

  assign s2a[0] = s2_item_q.ax;
  assign s2a[1] = s2_item_q.ay;
  assign s2a[2] = s2_item_q.az;
  assign s2b[0] = s2_item_q.bx;
  assign s2b[1] = s2_item_q.by;
  assign s2b[2] = s2_item_q.bz;

  assign dneg     = dsum_q[ACC_W-1];
  assign dabs     = dneg ? -dsum_q : dsum_q;
  assign sq_last  = (cnt_q == CNT_W'(SQRT_STEPS - 1));
  assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign ex_load  = s2_go && s2_item_q.iter;

  // One result bit of the square root per cycle
  assign sq_sh  = SH_W'(PROD_W - 2) - SH_W'({cnt_q[SQ_CW-1:0], 1'b0});
  assign sq_bit = PROD_W'(1) << sq_sh;
  assign sq_try = sqr_q + sq_bit;

  always_comb begin
    if (sqs_q >= sq_try) begin
      sqs_d = sqs_q - sq_try;
      sqr_d = (sqr_q >> 1) + sq_bit;
    end else begin
      sqs_d = sqs_q;
      sqr_d = sqr_q >> 1;
    end
  end

  // Three restoring divider lanes sharing one divisor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_u[i] = mag_q[i] * (cnt_q[0] ? dm_q[PROD_W-1:DATA_W] : dm_q[DATA_W-1:0]);
      rsh[i]    = {rem_q[i], num_q[i][NUM_W-1]};
      rdiff[i]  = rsh[i] - {1'b0, dv_q};
      if (rsh[i] >= {1'b0, dv_q}) begin
        rem_d[i] = rdiff[i][PROD_W-1:0];
        num_d[i] = {num_q[i][NUM_W-2:0], 1'b1};
      end else begin
        rem_d[i] = rsh[i][PROD_W-1:0];
        num_d[i] = {num_q[i][NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    ex_d   = ex_q;
    cnt_d  = cnt_q;
    zdiv_d = zdiv_q;
    case (ex_q)
      EX_IDLE: begin
        if (ex_load) begin
          cnt_d  = '0;
          zdiv_d = 1'b0;
          case (s2_item_q.op)
            CMD_MAG: ex_d = EX_SQRT;
            CMD_NORM: begin
              ex_d   = s2_item_q.a_zero ? EX_DONE : EX_SQRT;
              zdiv_d = s2_item_q.a_zero;
            end
            default: begin
              ex_d   = s2_item_q.b_zero ? EX_DONE : EX_MUL;
              zdiv_d = s2_item_q.b_zero;
            end
          endcase
        end
      end
      EX_SQRT: begin
        if (sq_last) begin
          cnt_d = '0;
          ex_d  = (ex_op_q == CMD_MAG) ? EX_DONE : EX_DIV;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      EX_MUL: begin
        if (cnt_q[0]) begin
          cnt_d = '0;
          ex_d  = EX_DIV;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      EX_DIV: begin
        if (div_last) begin
          ex_d = EX_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      EX_DONE: begin
        if (!full_i) begin
          ex_d = EX_IDLE;
        end
      end
      default: ex_d = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ex_q)
      EX_IDLE: begin
        if (ex_load) begin
          ex_op_q <= s2_item_q.op;
          sqs_q   <= dsum_q[PROD_W-1:0];
          sqr_q   <= '0;
          dm_q    <= dabs[PROD_W-1:0];
          dv_q    <= nsum_q[PROD_W-1:0];
          for (int i = 0; i < 3; i++) begin
            if (s2_item_q.op == CMD_NORM) begin
              mag_q[i] <= mag32(s2a[i]);
              neg_q[i] <= s2a[i][DATA_W-1];
            end else begin
              mag_q[i] <= mag32(s2b[i]);
              neg_q[i] <= s2b[i][DATA_W-1] ^ dneg;
            end
          end
        end
      end
      EX_SQRT: begin
        sqs_q <= sqs_d;
        sqr_q <= sqr_d;
        if (sq_last) begin
          dv_q <= sqr_d;
          for (int i = 0; i < 3; i++) begin
            num_q[i] <= NUM_W'(mag_q[i]) << FRAC_BITS;
            rem_q[i] <= '0;
          end
        end
      end
      EX_MUL: begin
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= '0;
          if (cnt_q[0]) begin
            num_q[i] <= num_q[i] + {prod_u[i], {DATA_W{1'b0}}};
          end else begin
            num_q[i] <= NUM_W'(prod_u[i]);
          end
        end
      end
      EX_DIV: begin
        for (int i = 0; i < 3; i++) begin
          num_q[i] <= num_d[i];
          rem_q[i] <= rem_d[i];
        end
      end
      default: ;
    endcase
  end

  // ---------------- result select
  sat_t sv [3];
  sat_t dq [3];
  sat_t ss, ms;
  res_t simple_res, done_res;

  always_comb begin
    simple_res = '0;
    for (int i = 0; i < 3; i++) begin
      if ((s2_item_q.op == CMD_SCALE) || (s2_item_q.op == CMD_CROSS)) begin
        sv[i] = sat_acc(v_q[i] >>> FRAC_BITS);
      end else begin
        sv[i] = sat_acc(v_q[i]);
      end
    end
    ss = '0;
    if (s2_item_q.op == CMD_DOT) begin
      ss = sat_acc(dsum_q >>> FRAC_BITS);
    end
    simple_res.rx     = sv[0].val;
    simple_res.ry     = sv[1].val;
    simple_res.rz     = sv[2].val;
    simple_res.sc     = ss.val;
    simple_res.status = (sv[0].ovf || sv[1].ovf || sv[2].ovf || ss.ovf) ? ST_SAT : ST_OK;
  end

  always_comb begin
    done_res = '0;
    for (int i = 0; i < 3; i++) begin
      dq[i] = sat_mag(num_q[i], neg_q[i]);
    end
    ms = sat_mag(NUM_W'(sqr_q), 1'b0);
    if (zdiv_q) begin
      done_res.status = ST_ZDIV;
    end else if (ex_op_q == CMD_MAG) begin
      done_res.sc     = ms.val;
      done_res.status = ms.ovf ? ST_SAT : ST_OK;
    end else begin
      done_res.rx     = dq[0].val;
      done_res.ry     = dq[1].val;
      done_res.rz     = dq[2].val;
      done_res.status = (dq[0].ovf || dq[1].ovf || dq[2].ovf) ? ST_SAT : ST_OK;
    end
  end

  // ---------------- pipeline control
  assign s2_go  = s2_valid_q && (ex_q == EX_IDLE) && (s2_item_q.iter || !full_i);
  assign s2_en  = !s2_valid_q || s2_go;
  assign s1_en  = !s1_valid_q || s2_en;
  assign pop_o  = !empty_i && s1_en;
  assign push_o = !full_i && ((ex_q == EX_DONE) ||
                  (s2_valid_q && (ex_q == EX_IDLE) && !s2_item_q.iter));
  assign res_o  = (ex_q == EX_DONE) ? done_res : simple_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      ex_q       <= EX_IDLE;
      cnt_q      <= '0;
      zdiv_q     <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= pop_o;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      ex_q   <= ex_d;
      cnt_q  <= cnt_d;
      zdiv_q <= zdiv_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vector3_alu.sv =====
// Top level of the three-component vector ALU.
`default_nettype none

// Signed fixed-point vector ALU with queue-style ports on both sides. Items go
// through a decode stage and a command queue into a two-stage product and sum
// pipeline; add, subtract, scale, dot and cross issue one item per cycle while
// the result queue has room and the iterative unit is idle. Magnitude,
// projection and normalize run in one shared iterative unit that holds the
// pipeline behind it: magnitude computes one square-root bit per cycle,
// projection forms two partial products and then one quotient bit per cycle
// over 96 bits in three lanes, and normalize runs the square root, then the
// divide. Projection onto a zero vector or normalizing a zero vector finishes
// at once with zeros and the zero-divisor status. Results saturate and flag
// status 1.
module vector3_alu #(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [3:0]                        cmd_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] ax_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] ay_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] az_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] bx_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] by_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] bz_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] scalar_in_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [v3a_pkg::DATA_W-1:0]      rx_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      ry_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      rz_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      scalar_out_o,
  output logic [1:0]                             status_o
);

  import v3a_pkg::*;

  logic                    q_push, q_full, q_empty, q_pop;
  item_t                   q_item_in, q_item_out;
  logic [$bits(item_t)-1:0] q_data;
  logic                    res_push, res_full;
  res_t                    res_in, res_out;
  logic [$bits(res_t)-1:0] res_data;

  v3a_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_i),
    .ax_i     (ax_i),
    .ay_i     (ay_i),
    .az_i     (az_i),
    .bx_i     (bx_i),
    .by_i     (by_i),
    .bz_i     (bz_i),
    .sc_i     (scalar_in_i),
    .full_o   (full),
    .q_push_o (q_push),
    .q_item_o (q_item_in),
    .q_full_i (q_full)
  );

  v3a_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_item_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  assign q_item_out = item_t'(q_data);

  v3a_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item_out),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .res_o   (res_in),
    .push_o  (res_push),
    .full_i  (res_full)
  );

  v3a_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign res_out      = res_t'(res_data);
  assign rx_o         = res_out.rx;
  assign ry_o         = res_out.ry;
  assign rz_o         = res_out.rz;
  assign scalar_out_o = res_out.sc;
  assign status_o     = res_out.status;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result written into a full result queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command written into a full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_ZDIV) |->
      (rx_o == '0 && ry_o == '0 && rz_o == '0 && scalar_out_o == '0))
    else $error("zero-divisor result carries nonzero values");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && scalar_out_o != '0) |-> (rx_o == '0 && ry_o == '0 && rz_o == '0))
    else $error("scalar result carries a nonzero vector");
`endif

endmodule

`default_nettype wire
